// ===== rtl/core/ascii_target_to_diff_drive_macros.svh =====
// Assertion macros shared by the checker
`ifndef ASCII_TARGET_TO_DIFF_DRIVE_MACROS_SVH
`define ASCII_TARGET_TO_DIFF_DRIVE_MACROS_SVH

// Condition holds in the same cycle as the trigger
`define ATDD_ASSERT_NOW(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition holds in the cycle after the trigger
`define ATDD_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== rtl/core/atdd_pkg.sv =====
package atdd_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_BACK_WIDTH     = 3'd0;
    localparam logic [2:0] REG_CREEP_WIDTH    = 3'd1;
    localparam logic [2:0] REG_MODERATE_WIDTH = 3'd2;
    localparam logic [2:0] REG_CENTER_COLUMN  = 3'd3;
    localparam logic [2:0] REG_STEER_DEADBAND = 3'd4;
    localparam logic [2:0] REG_REVERSE_SPEED  = 3'd5;
    localparam logic [2:0] REG_MODERATE_SPEED = 3'd6;
    localparam logic [2:0] REG_FAST_SPEED     = 3'd7;

    localparam logic [14:0] RST_BACK_WIDTH     = 15'd480;
    localparam logic [14:0] RST_CREEP_WIDTH    = 15'd400;
    localparam logic [14:0] RST_MODERATE_WIDTH = 15'd350;
    localparam logic [11:0] RST_CENTER_COLUMN  = 12'd320;
    localparam logic [11:0] RST_STEER_DEADBAND = 12'd40;
    localparam logic [9:0]  RST_REVERSE_SPEED  = 10'd550;
    localparam logic [9:0]  RST_MODERATE_SPEED = 10'd700;
    localparam logic [9:0]  RST_FAST_SPEED     = 10'd750;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [2:0] FIELD_X     = 3'd0;
    localparam logic [2:0] FIELD_WIDTH = 3'd2;
    localparam logic [2:0] FIELD_LIMIT = 3'd4;

    localparam logic [15:0] ACC_LIMIT = 16'd32768;
    localparam logic [15:0] POS_LIMIT = 16'd32767;

    localparam logic [1:0] MODE_STOP     = 2'd0;
    localparam logic [1:0] MODE_FORWARD  = 2'd1;
    localparam logic [1:0] MODE_BACKWARD = 2'd2;

    typedef enum logic [2:0] {
        PH_SKIP = 3'b001,
        PH_NUM  = 3'b010,
        PH_DONE = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        K_STOP  = 2'd0,
        K_BACK  = 2'd1,
        K_STEER = 2'd2
    } kind_t;

    typedef struct packed {
        logic [14:0] back_width_limit;
        logic [14:0] creep_width_limit;
        logic [14:0] moderate_width_limit;
        logic [11:0] center_column;
        logic [11:0] steer_deadband;
        logic [9:0]  reverse_speed;
        logic [9:0]  moderate_speed;
        logic [9:0]  fast_speed;
    } cfg_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] width;
    } target_t;

    typedef struct packed {
        kind_t       kind;
        logic [9:0]  base;
        logic [17:0] err;
    } steer_t;

endpackage

// ===== rtl/core/atdd_front.sv =====
module atdd_front #(
    parameter int LINE_BYTES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               push_valid,
    input  logic               push_ready,
    output atdd_pkg::target_t  push_data
);

    localparam int CW = $clog2(LINE_BYTES);
    localparam logic [CW-1:0] LAST_COUNT = CW'(LINE_BYTES - 1);

    logic [CW-1:0]       byte_count_reg, byte_count_next;
    logic [2:0]          field_number_reg, field_number_next;
    atdd_pkg::phase_t    phase_reg, phase_next;
    logic                minus_reg, minus_next;
    logic [15:0]         acc_reg, acc_next;
    logic                text_ended_reg, text_ended_next;
    logic [15:0]         pend_x_reg, pend_x_next;
    logic [15:0]         pend_w_reg, pend_w_next;
    logic                w_seen_reg, w_seen_next;
    logic [15:0]         last_w_reg, last_w_next;

    logic        accept;
    logic        is_nl;
    logic        is_space;
    logic        is_digit;
    logic        live;
    logic        do_finish;
    logic        num_byte;
    logic [15:0] field_val;
    logic [19:0] acc_mul;
    logic        nl_finish;
    logic [15:0] line_x;
    logic [15:0] line_w;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign is_nl    = (rx_byte == atdd_pkg::CH_NL);
    assign is_space = (rx_byte == atdd_pkg::CH_SPACE)
                   || ((rx_byte >= atdd_pkg::CH_TAB) && (rx_byte <= atdd_pkg::CH_CR));
    assign is_digit = (rx_byte >= atdd_pkg::CH_ZERO) && (rx_byte <= atdd_pkg::CH_NINE);
    assign live     = !text_ended_reg && (field_number_reg < atdd_pkg::FIELD_LIMIT);

    assign field_val = minus_reg ? (16'd0 - acc_reg)
                     : ((acc_reg > atdd_pkg::POS_LIMIT) ? atdd_pkg::POS_LIMIT : acc_reg);

    assign acc_mul = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                   + {16'd0, rx_byte[3:0]};

    assign nl_finish = live;
    assign line_x = (nl_finish && field_number_reg == atdd_pkg::FIELD_X) ? field_val
                  : pend_x_reg;
    assign line_w = (nl_finish && field_number_reg == atdd_pkg::FIELD_WIDTH) ? field_val
                  : (w_seen_reg ? pend_w_reg : last_w_reg);

    assign push_valid      = accept && is_nl;
    assign push_data.x     = line_x;
    assign push_data.width = line_w;

    always_comb
    begin
        byte_count_next   = byte_count_reg;
        field_number_next = field_number_reg;
        phase_next        = phase_reg;
        minus_next        = minus_reg;
        acc_next          = acc_reg;
        text_ended_next   = text_ended_reg;
        pend_x_next       = pend_x_reg;
        pend_w_next       = pend_w_reg;
        w_seen_next       = w_seen_reg;
        last_w_next       = last_w_reg;
        do_finish         = 1'b0;
        num_byte          = 1'b0;

        if (accept)
        begin
            if (is_nl)
            begin
                last_w_next = line_w;
            end
            else if (byte_count_reg < LAST_COUNT)
            begin
                byte_count_next = byte_count_reg + CW'(1);
                if (live)
                begin
                    if (rx_byte == atdd_pkg::CH_NUL)
                    begin
                        do_finish       = 1'b1;
                        text_ended_next = 1'b1;
                    end
                    else if (rx_byte == atdd_pkg::CH_COMMA)
                    begin
                        do_finish         = 1'b1;
                        field_number_next = field_number_reg + 3'd1;
                        phase_next        = atdd_pkg::PH_SKIP;
                        minus_next        = 1'b0;
                        acc_next          = 16'd0;
                    end
                    else
                    begin
                        case (phase_reg)
                            atdd_pkg::PH_SKIP:
                            begin
                                if (!is_space)
                                begin
                                    phase_next = atdd_pkg::PH_NUM;
                                    if (rx_byte == atdd_pkg::CH_MINUS)
                                        minus_next = 1'b1;
                                    else if (rx_byte != atdd_pkg::CH_PLUS)
                                        num_byte = 1'b1;
                                end
                            end
                            atdd_pkg::PH_NUM:
                            begin
                                num_byte = 1'b1;
                            end
                            default:
                            begin
                                num_byte = 1'b0;
                            end
                        endcase
                        if (num_byte)
                        begin
                            if (is_digit)
                                acc_next = (acc_mul > {4'd0, atdd_pkg::ACC_LIMIT})
                                         ? atdd_pkg::ACC_LIMIT : acc_mul[15:0];
                            else
                                phase_next = atdd_pkg::PH_DONE;
                        end
                    end
                end
            end

            // newline or overlong line: restart the line
            if (is_nl || !(byte_count_reg < LAST_COUNT))
            begin
                byte_count_next   = '0;
                field_number_next = atdd_pkg::FIELD_X;
                phase_next        = atdd_pkg::PH_SKIP;
                minus_next        = 1'b0;
                acc_next          = 16'd0;
                text_ended_next   = 1'b0;
                pend_x_next       = 16'd0;
                pend_w_next       = 16'd0;
                w_seen_next       = 1'b0;
            end
            else if (do_finish)
            begin
                if (field_number_reg == atdd_pkg::FIELD_X)
                    pend_x_next = field_val;
                else if (field_number_reg == atdd_pkg::FIELD_WIDTH)
                begin
                    pend_w_next = field_val;
                    w_seen_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            field_number_reg <= atdd_pkg::FIELD_X;
            phase_reg        <= atdd_pkg::PH_SKIP;
            minus_reg        <= 1'b0;
            acc_reg          <= 16'd0;
            text_ended_reg   <= 1'b0;
            pend_x_reg       <= 16'd0;
            pend_w_reg       <= 16'd0;
            w_seen_reg       <= 1'b0;
            last_w_reg       <= 16'd0;
        end
        else
        begin
            byte_count_reg   <= byte_count_next;
            field_number_reg <= field_number_next;
            phase_reg        <= phase_next;
            minus_reg        <= minus_next;
            acc_reg          <= acc_next;
            text_ended_reg   <= text_ended_next;
            pend_x_reg       <= pend_x_next;
            pend_w_reg       <= pend_w_next;
            w_seen_reg       <= w_seen_next;
            last_w_reg       <= last_w_next;
        end
    end

endmodule

// ===== rtl/core/atdd_queue.sv =====
module atdd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  atdd_pkg::target_t  push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output atdd_pkg::target_t  pop_data
);

    atdd_pkg::target_t mem [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/atdd_back.sv =====
module atdd_back #(
    parameter int MAX_DUTY = 799
) (
    input  logic               clk,
    input  logic               rst_n,
    input  atdd_pkg::cfg_t     cfg,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  atdd_pkg::target_t  pop_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         drive_mode,
    output logic [9:0]         left_duty,
    output logic [9:0]         right_duty
);

    localparam logic signed [19:0] DUTY_CAP = 20'(MAX_DUTY);

    logic             a_valid_reg;
    atdd_pkg::steer_t a_reg, a_next;
    logic             o_valid_reg;
    logic [1:0]       mode_reg, mode_next;
    logic [9:0]       left_reg, left_next;
    logic [9:0]       right_reg, right_next;

    logic a_ready;
    logic b_ready;

    logic signed [16:0] w_ext;
    logic signed [15:0] half_w;
    logic signed [17:0] err_a;

    logic signed [17:0] err_b;
    logic        [17:0] mag;
    logic signed [19:0] base_b;
    logic signed [19:0] twice;
    logic signed [19:0] l_raw;
    logic signed [19:0] r_raw;
    logic signed [19:0] l_clip;
    logic signed [19:0] r_clip;

    assign b_ready   = !o_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign pop_ready = a_ready;

    // classify the target and form the column error
    always_comb
    begin
        w_ext  = $signed({pop_data.width[15], pop_data.width});
        half_w = ($signed(pop_data.width) + $signed({15'd0, pop_data.width[15]})) >>> 1;
        err_a  = $signed({{2{pop_data.x[15]}}, pop_data.x})
               + $signed({{2{half_w[15]}}, half_w})
               - $signed({6'd0, cfg.center_column});

        a_next.err  = err_a;
        a_next.base = cfg.fast_speed;
        a_next.kind = atdd_pkg::K_STEER;
        if (pop_data.width == 16'd0)
        begin
            a_next.kind = atdd_pkg::K_STOP;
        end
        else if (w_ext > $signed({2'd0, cfg.back_width_limit}))
        begin
            a_next.kind = atdd_pkg::K_BACK;
            a_next.base = cfg.reverse_speed;
        end
        else if (w_ext > $signed({2'd0, cfg.creep_width_limit}))
        begin
            a_next.base = {1'b0, cfg.reverse_speed[9:1]};
        end
        else if (w_ext > $signed({2'd0, cfg.moderate_width_limit}))
        begin
            a_next.base = cfg.moderate_speed;
        end
    end

    // resolve duties
    always_comb
    begin
        err_b  = $signed(a_reg.err);
        mag    = err_b[17] ? 18'(-err_b) : a_reg.err;
        base_b = $signed({10'd0, a_reg.base});
        twice  = $signed({err_b[17], a_reg.err, 1'b0});
        l_raw  = base_b + twice;
        r_raw  = base_b - twice;
        l_clip = l_raw[19] ? 20'sd0 : ((l_raw > DUTY_CAP) ? DUTY_CAP : l_raw);
        r_clip = r_raw[19] ? 20'sd0 : ((r_raw > DUTY_CAP) ? DUTY_CAP : r_raw);

        mode_next  = atdd_pkg::MODE_STOP;
        left_next  = 10'd0;
        right_next = 10'd0;
        case (a_reg.kind)
            atdd_pkg::K_STOP:
            begin
                mode_next = atdd_pkg::MODE_STOP;
            end
            atdd_pkg::K_BACK:
            begin
                mode_next  = atdd_pkg::MODE_BACKWARD;
                left_next  = a_reg.base;
                right_next = a_reg.base;
            end
            atdd_pkg::K_STEER:
            begin
                if (mag <= {6'd0, cfg.steer_deadband})
                begin
                    mode_next  = atdd_pkg::MODE_FORWARD;
                    left_next  = a_reg.base;
                    right_next = a_reg.base;
                end
                else if ((l_clip != 20'sd0) || (r_clip != 20'sd0))
                begin
                    mode_next  = atdd_pkg::MODE_FORWARD;
                    left_next  = l_clip[9:0];
                    right_next = r_clip[9:0];
                end
            end
            default:
            begin
                mode_next = atdd_pkg::MODE_STOP;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && a_ready)
            a_reg <= a_next;
        if (a_valid_reg && b_ready)
        begin
            mode_reg  <= mode_next;
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= pop_valid;
            if (b_ready)
                o_valid_reg <= a_valid_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign drive_mode = mode_reg;
    assign left_duty  = left_reg;
    assign right_duty = right_reg;

endmodule

// ===== rtl/core/ascii_target_to_diff_drive.sv =====
// Channel   Handshake               Payload
// in        in_valid / in_ready     rx_byte
// out       out_valid / out_ready   drive_mode, left_duty, right_duty
// cfg       psel / penable / pwrite paddr, pwdata, prdata (pready tied high)
//
// One byte per cycle is taken while the queue has room; the parser finishes each
// byte in the cycle it arrives. A newline's target passes through a two-entry queue
// and a two-stage drive pipeline (classify, then registered drive outputs) to out.
// in_ready drops only while the queue is full; out stalls back up through it.
// Reset clears parser, queue and pipeline control; registers take their defaults.
module ascii_target_to_diff_drive #(
    parameter int LINE_BYTES = 32,
    parameter int MAX_DUTY   = 799
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  drive_mode,
    output logic [9:0]                  left_duty,
    output logic [9:0]                  right_duty,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [atdd_pkg::ADDR_W-1:0] paddr,
    input  logic [atdd_pkg::DATA_W-1:0] pwdata,
    output logic [atdd_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    atdd_pkg::cfg_t    cfg_reg;
    logic              wr_en;
    logic [2:0]        reg_idx;
    logic              push_valid;
    logic              push_ready;
    atdd_pkg::target_t push_data;
    logic              pop_valid;
    logic              pop_ready;
    atdd_pkg::target_t pop_data;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.back_width_limit     <= atdd_pkg::RST_BACK_WIDTH;
            cfg_reg.creep_width_limit    <= atdd_pkg::RST_CREEP_WIDTH;
            cfg_reg.moderate_width_limit <= atdd_pkg::RST_MODERATE_WIDTH;
            cfg_reg.center_column        <= atdd_pkg::RST_CENTER_COLUMN;
            cfg_reg.steer_deadband       <= atdd_pkg::RST_STEER_DEADBAND;
            cfg_reg.reverse_speed        <= atdd_pkg::RST_REVERSE_SPEED;
            cfg_reg.moderate_speed       <= atdd_pkg::RST_MODERATE_SPEED;
            cfg_reg.fast_speed           <= atdd_pkg::RST_FAST_SPEED;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                atdd_pkg::REG_BACK_WIDTH:     cfg_reg.back_width_limit     <= pwdata[14:0];
                atdd_pkg::REG_CREEP_WIDTH:    cfg_reg.creep_width_limit    <= pwdata[14:0];
                atdd_pkg::REG_MODERATE_WIDTH: cfg_reg.moderate_width_limit <= pwdata[14:0];
                atdd_pkg::REG_CENTER_COLUMN:  cfg_reg.center_column        <= pwdata[11:0];
                atdd_pkg::REG_STEER_DEADBAND: cfg_reg.steer_deadband       <= pwdata[11:0];
                atdd_pkg::REG_REVERSE_SPEED:  cfg_reg.reverse_speed        <= pwdata[9:0];
                atdd_pkg::REG_MODERATE_SPEED: cfg_reg.moderate_speed       <= pwdata[9:0];
                atdd_pkg::REG_FAST_SPEED:     cfg_reg.fast_speed           <= pwdata[9:0];
                default:                      cfg_reg.fast_speed           <= cfg_reg.fast_speed;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            atdd_pkg::REG_BACK_WIDTH:     prdata = {17'd0, cfg_reg.back_width_limit};
            atdd_pkg::REG_CREEP_WIDTH:    prdata = {17'd0, cfg_reg.creep_width_limit};
            atdd_pkg::REG_MODERATE_WIDTH: prdata = {17'd0, cfg_reg.moderate_width_limit};
            atdd_pkg::REG_CENTER_COLUMN:  prdata = {20'd0, cfg_reg.center_column};
            atdd_pkg::REG_STEER_DEADBAND: prdata = {20'd0, cfg_reg.steer_deadband};
            atdd_pkg::REG_REVERSE_SPEED:  prdata = {22'd0, cfg_reg.reverse_speed};
            atdd_pkg::REG_MODERATE_SPEED: prdata = {22'd0, cfg_reg.moderate_speed};
            atdd_pkg::REG_FAST_SPEED:     prdata = {22'd0, cfg_reg.fast_speed};
            default:                      prdata = '0;
        endcase
    end

    atdd_front #(
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    atdd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    atdd_back #(
        .MAX_DUTY (MAX_DUTY)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive_mode (drive_mode),
        .left_duty  (left_duty),
        .right_duty (right_duty)
    );

endmodule

// ===== rtl/core/atdd_checker.sv =====
`include "ascii_target_to_diff_drive_macros.svh"

module atdd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] drive_mode,
    input logic [9:0] left_duty,
    input logic [9:0] right_duty
);

    logic out_wait;
    logic mode_ok;
    logic is_stop;
    logic is_back;
    logic duty_zero;
    logic duty_even;

    assign out_wait  = out_valid && !out_ready;
    assign mode_ok   = (drive_mode == atdd_pkg::MODE_STOP)
                    || (drive_mode == atdd_pkg::MODE_FORWARD)
                    || (drive_mode == atdd_pkg::MODE_BACKWARD);
    assign is_stop   = out_valid && (drive_mode == atdd_pkg::MODE_STOP);
    assign is_back   = out_valid && (drive_mode == atdd_pkg::MODE_BACKWARD);
    assign duty_zero = (left_duty == 10'd0) && (right_duty == 10'd0);
    assign duty_even = (left_duty == right_duty);

    `ATDD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid, "out transfer dropped")
    `ATDD_ASSERT_NOW(a_mode_code, clk, rst_n, out_valid, mode_ok, "invalid drive mode")
    `ATDD_ASSERT_NOW(a_stop_zero, clk, rst_n, is_stop, duty_zero, "stop with nonzero duty")
    `ATDD_ASSERT_NOW(a_back_even, clk, rst_n, is_back, duty_even, "uneven reverse duty")

endmodule

bind ascii_target_to_diff_drive atdd_checker u_atdd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .drive_mode (drive_mode),
    .left_duty  (left_duty),
    .right_duty (right_duty)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int LINE_LEN     = 32;
    localparam int DUTY_MAX     = 799;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 400;

    localparam logic [7:0] CH_VT = 8'd11;
    localparam logic [7:0] CH_FF = 8'd12;

    typedef struct packed {
        logic [1:0] mode;
        logic [9:0] left;
        logic [9:0] right;
    } drive_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  drive_mode;
    logic [9:0]  left_duty;
    logic [9:0]  right_duty;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [atdd_pkg::ADDR_W-1:0] paddr = '0;
    logic [atdd_pkg::DATA_W-1:0] pwdata = '0;
    logic [atdd_pkg::DATA_W-1:0] prdata;
    logic        pready;

    ascii_target_to_diff_drive #(
        .LINE_BYTES (LINE_LEN),
        .MAX_DUTY   (DUTY_MAX)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive_mode (drive_mode),
        .left_duty  (left_duty),
        .right_duty (right_duty),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Line parser and steering state
    atdd_pkg::cfg_t    regs_now;
    int                byte_cnt;
    int                fld_num;
    atdd_pkg::phase_t  fld_phase;
    logic              minus_seen;
    logic [16:0]       digits;
    logic              text_done;
    logic signed [15:0] pend_x;
    logic signed [15:0] pend_w;
    logic              w_seen;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_w;

    logic [7:0]  byte_q[$];
    drive_cmd_t  pending_cmds[$];
    drive_cmd_t  new_cmd;
    drive_cmd_t  want;
    int          bytes_queued = 0;
    int          bytes_taken = 0;
    int          cmds_seen = 0;
    int          errors = 0;
    int          settings = 0;
    int          cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    bit          hold_done = 0;
    int          pat_left = 0;
    int          pat_mode = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void start_field();
        fld_phase  = atdd_pkg::PH_SKIP;
        minus_seen = 1'b0;
        digits     = '0;
    endfunction

    function automatic void start_line();
        byte_cnt  = 0;
        fld_num   = 0;
        text_done = 1'b0;
        pend_x    = '0;
        pend_w    = '0;
        w_seen    = 1'b0;
        start_field();
    endfunction

    function automatic void close_field();
        int v;
        if (minus_seen)
            v = -int'(digits);
        else
            v = (digits > 17'd32767) ? 32767 : int'(digits);
        if (fld_num == atdd_pkg::FIELD_X)
            pend_x = v[15:0];
        else if (fld_num == atdd_pkg::FIELD_WIDTH)
        begin
            pend_w = v[15:0];
            w_seen = 1'b1;
        end
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        int acc;
        if (text_done || fld_num >= atdd_pkg::FIELD_LIMIT)
            return;
        if (c == atdd_pkg::CH_NUL)
        begin
            close_field();
            text_done = 1'b1;
            return;
        end
        if (c == atdd_pkg::CH_COMMA)
        begin
            close_field();
            fld_num++;
            start_field();
            return;
        end
        if (fld_phase == atdd_pkg::PH_SKIP)
        begin
            if (c == atdd_pkg::CH_SPACE || (c >= atdd_pkg::CH_TAB && c <= atdd_pkg::CH_CR))
                return;
            fld_phase = atdd_pkg::PH_NUM;
            if (c == atdd_pkg::CH_MINUS)
            begin
                minus_seen = 1'b1;
                return;
            end
            if (c == atdd_pkg::CH_PLUS)
                return;
        end
        if (fld_phase == atdd_pkg::PH_NUM)
        begin
            if (c >= atdd_pkg::CH_ZERO && c <= atdd_pkg::CH_NINE)
            begin
                acc = int'(digits) * 10 + int'(c - atdd_pkg::CH_ZERO);
                digits = (acc > 32768) ? 17'd32768 : acc[16:0];
            end
            else
                fld_phase = atdd_pkg::PH_DONE;
        end
    endfunction

    function automatic int clamp_duty(input int v);
        if (v > DUTY_MAX)
            return DUTY_MAX;
        if (v < 0)
            return 0;
        return v;
    endfunction

    function automatic drive_cmd_t steer_command();
        drive_cmd_t cmd;
        int w, base, err, mag, l, r;
        w = int'(cur_w);
        cmd.mode  = atdd_pkg::MODE_STOP;
        cmd.left  = '0;
        cmd.right = '0;
        if (w == 0)
            return cmd;
        if (w > int'(regs_now.back_width_limit))
        begin
            cmd.mode  = atdd_pkg::MODE_BACKWARD;
            cmd.left  = regs_now.reverse_speed;
            cmd.right = regs_now.reverse_speed;
            return cmd;
        end
        if (w > int'(regs_now.creep_width_limit))
            base = int'(regs_now.reverse_speed) / 2;
        else if (w > int'(regs_now.moderate_width_limit))
            base = int'(regs_now.moderate_speed);
        else
            base = int'(regs_now.fast_speed);
        err = int'(cur_x) + w / 2 - int'(regs_now.center_column);
        mag = (err < 0) ? -err : err;
        if (mag <= int'(regs_now.steer_deadband))
        begin
            cmd.mode  = atdd_pkg::MODE_FORWARD;
            cmd.left  = base[9:0];
            cmd.right = base[9:0];
            return cmd;
        end
        l = clamp_duty(base + 2 * err);
        r = clamp_duty(base - 2 * err);
        if (l != 0 || r != 0)
        begin
            cmd.mode  = atdd_pkg::MODE_FORWARD;
            cmd.left  = l[9:0];
            cmd.right = r[9:0];
        end
        return cmd;
    endfunction

    function automatic bit feed_byte(input logic [7:0] c, output drive_cmd_t cmd);
        cmd = '0;
        if (c == atdd_pkg::CH_NL)
        begin
            if (!text_done && fld_num < atdd_pkg::FIELD_LIMIT)
                close_field();
            cur_x = pend_x;
            if (w_seen)
                cur_w = pend_w;
            start_line();
            cmd = steer_command();
            return 1'b1;
        end
        if (byte_cnt < LINE_LEN - 1)
        begin
            parse_char(c);
            byte_cnt++;
        end
        else
            start_line();
        return 1'b0;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        byte_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_number(input int v);
        int r;
        r = $urandom_range(0, 15);
        if (r < 3)
        begin
            case ($urandom_range(0, 4))
                0: push_byte(atdd_pkg::CH_TAB);
                1: push_byte(CH_VT);
                2: push_byte(CH_FF);
                3: push_byte(atdd_pkg::CH_CR);
                default: push_byte(atdd_pkg::CH_SPACE);
            endcase
        end
        if (v < 0)
            push_byte(atdd_pkg::CH_MINUS);
        else if (r == 3)
            push_byte(atdd_pkg::CH_PLUS);
        // drop the digits: empty field, or a sign alone
        if (r == 4)
            return;
        push_str($sformatf("%0d", (v < 0) ? -v : v));
        if (r == 5)
            push_str($sformatf("%c", 8'd97 + $urandom_range(0, 25)));
    endtask

    task automatic push_line();
        int kind, w, x, spread, n_fields, len;
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 8))
            0: w = 0;
            1: w = int'(regs_now.moderate_width_limit) + $urandom_range(0, 4) - 2;
            2: w = int'(regs_now.creep_width_limit) + $urandom_range(0, 4) - 2;
            3: w = int'(regs_now.back_width_limit) + $urandom_range(0, 4) - 2;
            4: w = -$urandom_range(1, 500);
            5: w = $urandom_range(0, 40000);
            default: w = $urandom_range(1, 600);
        endcase
        spread = int'(regs_now.steer_deadband) + 300;
        x = int'(regs_now.center_column) - w / 2 + $urandom_range(0, 2 * spread) - spread;
        if ($urandom_range(0, 15) == 0)
            x = $urandom_range(0, 199998) - 99999;
        if (kind < 70)
        begin
            n_fields = ($urandom_range(0, 4) != 0) ? 4 : $urandom_range(1, 6);
            for (int f = 0; f < n_fields; f++)
            begin
                if (f > 0)
                    push_byte(atdd_pkg::CH_COMMA);
                case (f)
                    0: push_number(x);
                    2: push_number(w);
                    default: push_number($urandom_range(0, 480));
                endcase
            end
        end
        else if (kind < 80)
        begin
            len = $urandom_range(29, 45);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                    push_byte(atdd_pkg::CH_COMMA);
                else
                    push_byte(8'(atdd_pkg::CH_ZERO + $urandom_range(0, 9)));
            end
        end
        else if (kind < 90)
        begin
            push_number(x);
            push_byte(atdd_pkg::CH_NUL);
            push_str(",9,");
            push_number(w);
        end
        else
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                push_byte(8'($urandom_range(0, 255)));
        end
        push_byte(atdd_pkg::CH_NL);
    endtask

    task automatic fill_random(input int n);
        int goal;
        goal = bytes_queued + n;
        while (bytes_queued < goal)
            push_line();
    endtask

    task automatic cfg_write(input logic [2:0] idx, input int unsigned val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            atdd_pkg::REG_BACK_WIDTH:     regs_now.back_width_limit     = val[14:0];
            atdd_pkg::REG_CREEP_WIDTH:    regs_now.creep_width_limit    = val[14:0];
            atdd_pkg::REG_MODERATE_WIDTH: regs_now.moderate_width_limit = val[14:0];
            atdd_pkg::REG_CENTER_COLUMN:  regs_now.center_column        = val[11:0];
            atdd_pkg::REG_STEER_DEADBAND: regs_now.steer_deadband       = val[11:0];
            atdd_pkg::REG_REVERSE_SPEED:  regs_now.reverse_speed        = val[9:0];
            atdd_pkg::REG_MODERATE_SPEED: regs_now.moderate_speed       = val[9:0];
            default:                      regs_now.fast_speed           = val[9:0];
        endcase
    endtask

    task automatic set_cfg(input int back, input int creep, input int moderate,
                           input int center, input int dead, input int rev,
                           input int mod_spd, input int fast);
        cfg_write(atdd_pkg::REG_BACK_WIDTH, back);
        cfg_write(atdd_pkg::REG_CREEP_WIDTH, creep);
        cfg_write(atdd_pkg::REG_MODERATE_WIDTH, moderate);
        cfg_write(atdd_pkg::REG_CENTER_COLUMN, center);
        cfg_write(atdd_pkg::REG_STEER_DEADBAND, dead);
        cfg_write(atdd_pkg::REG_REVERSE_SPEED, rev);
        cfg_write(atdd_pkg::REG_MODERATE_SPEED, mod_spd);
        cfg_write(atdd_pkg::REG_FAST_SPEED, fast);
        settings++;
    endtask

    task automatic settle();
        while (bytes_taken != bytes_queued || pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Sender: bursts of transfers separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            rx_byte    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (byte_q.size() > 0)
            begin
                rx_byte  <= byte_q.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stall pattern of its own, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (!hold_done && byte_q.size() > 60)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (pat_left == 0)
                begin
                    pat_mode = $urandom_range(0, 3);
                    pat_left = $urandom_range(10, 80);
                end
                else
                    pat_left--;
                case (pat_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 1);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Monitor: predict on input transfers, compare on output transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                bytes_taken++;
                if (feed_byte(rx_byte, new_cmd))
                    pending_cmds.push_back(new_cmd);
            end
            if (out_valid && out_ready)
            begin
                cmds_seen++;
                if (pending_cmds.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected drive command, expected none, %s %0d %0d %0d",
                             $time, "got mode/left/right", drive_mode, left_duty, right_duty);
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    check_field("drive_mode", int'(want.mode), int'(drive_mode));
                    check_field("left_duty", int'(want.left), int'(left_duty));
                    check_field("right_duty", int'(want.right), int'(right_duty));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL ascii_target_to_diff_drive");
            $finish;
        end
    end

    initial
    begin
        int m, cr, bk;
        regs_now.back_width_limit     = atdd_pkg::RST_BACK_WIDTH;
        regs_now.creep_width_limit    = atdd_pkg::RST_CREEP_WIDTH;
        regs_now.moderate_width_limit = atdd_pkg::RST_MODERATE_WIDTH;
        regs_now.center_column        = atdd_pkg::RST_CENTER_COLUMN;
        regs_now.steer_deadband       = atdd_pkg::RST_STEER_DEADBAND;
        regs_now.reverse_speed        = atdd_pkg::RST_REVERSE_SPEED;
        regs_now.moderate_speed       = atdd_pkg::RST_MODERATE_SPEED;
        regs_now.fast_speed           = atdd_pkg::RST_FAST_SPEED;
        start_line();
        cur_x = '0;
        cur_w = '0;
        settings = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty line, saturated x with negative width, sign alone with extra fields,
        // missing width, text ended by NUL
        push_byte(atdd_pkg::CH_NL);
        push_str("+99999,,-7");
        push_byte(atdd_pkg::CH_NL);
        push_byte(atdd_pkg::CH_SPACE);
        push_byte(atdd_pkg::CH_TAB);
        push_str("-,1,600,2,9,9");
        push_byte(atdd_pkg::CH_NL);
        push_str("-99999,5");
        push_byte(atdd_pkg::CH_NL);
        push_str("5");
        push_byte(atdd_pkg::CH_NUL);
        push_str(",7,0");
        push_byte(8'hFF);
        push_byte(atdd_pkg::CH_NL);
        fill_random(160);
        settle();

        set_cfg(0, 0, 0, 0, 0, 0, 0, 0);
        fill_random(80);
        settle();

        set_cfg(32767, 32767, 32767, 4095, 4095, 1023, 1023, 1023);
        fill_random(80);
        settle();

        repeat (3)
        begin
            m  = $urandom_range(0, 600);
            cr = m + $urandom_range(0, 200);
            bk = cr + $urandom_range(0, 200);
            set_cfg(bk, cr, m, $urandom_range(0, 640), $urandom_range(0, 120),
                    $urandom_range(0, 799), $urandom_range(0, 799), $urandom_range(0, 799));
            fill_random(80);
            settle();
        end

        set_cfg(int'(atdd_pkg::RST_BACK_WIDTH), int'(atdd_pkg::RST_CREEP_WIDTH),
                int'(atdd_pkg::RST_MODERATE_WIDTH), int'(atdd_pkg::RST_CENTER_COLUMN),
                int'(atdd_pkg::RST_STEER_DEADBAND), int'(atdd_pkg::RST_REVERSE_SPEED),
                int'(atdd_pkg::RST_MODERATE_SPEED), int'(atdd_pkg::RST_FAST_SPEED));
        fill_random(60);
        settle();

        $display("Fed %0d bytes across %0d register settings; checked %0d drive commands.",
                 bytes_taken, settings, cmds_seen);
        $display("Long receiver hold-off applied: %0d; mismatches: %0d", hold_done, errors);
        if (errors == 0)
            $display("PASS ascii_target_to_diff_drive");
        else
            $display("FAIL ascii_target_to_diff_drive");
        $finish;
    end

endmodule
